### sv/ile_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed list engine.
// No dependencies.
package ile_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W    = 4;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 9;
  localparam int CURSOR_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 4'd0,
    CMD_INSERT    = 4'd1,
    CMD_REMOVE_AT = 4'd2,
    CMD_REMOVE_VAL = 4'd3,
    CMD_CLEAR     = 4'd4,
    CMD_GET       = 4'd5,
    CMD_FIRST     = 4'd6,
    CMD_NEXT      = 4'd7,
    CMD_REPLACE   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

### sv/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// Indexed list engine: ordered list in a single dual-port RAM with count and cursor.
// Depends on ile_pkg.
//
// Usage: one command item enters on in_valid/in_ready (in_cmd, in_position,
// in_value) and exactly one result item leaves on out_valid/out_ready
// (out_data_out, out_has_data, out_status, out_length, out_cursor).
// One item is in work at a time; the next one is taken as soon as the engine
// is back in idle, even while the previous result still sits in the output
// register waiting for out_ready.
// Steps after accept: append, clear, replace, errors, no-op and empty first/next
// pass straight to the result; get, first and next read one RAM entry; insert
// moves each entry from the top down to the position up a slot, then writes the
// new value (at the end it writes directly); remove at reads the entry at the
// position and remove value searches from the start for a match, then later
// entries move down a slot. Entries are shifted one per cycle, reading one
// address while the previous entry is written to its neighbor.
// Reset (rst_n low, synchronous) empties the list and zeroes the cursor; RAM
// contents are not cleared and no clearing pass is needed. A stalled receiver
// holds the result in the output register; the engine then finishes at most
// one more item and waits with it until the register frees up.
module indexed_list_engine_unit
  import ile_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [POS_W-1:0]    in_position,
  input  logic [VAL_W-1:0]    in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    out_data_out,
  output logic                out_has_data,
  output logic [1:0]          out_status,
  output logic [LEN_W-1:0]    out_length,
  output logic [CURSOR_W-1:0] out_cursor
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_HEAD,
    S_DN,
    S_RD,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          iter_r, iter_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   scan_r, scan_nxt;
  logic [VALUE_WIDTH-1:0] res_data_r, res_data_nxt;
  logic                   res_has_r, res_has_nxt;
  status_t                res_status_r, res_status_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]       out_data_r, out_data_nxt;
  logic                   out_has_r, out_has_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [LEN_W-1:0]       out_length_r, out_length_nxt;
  logic [CURSOR_W-1:0]    out_cursor_r, out_cursor_nxt;

  // RAM
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [VALUE_WIDTH-1:0] mem_wd, rd_q;

  logic                   in_acc, out_acc;
  logic [VALUE_WIDTH-1:0] in_val_w;
  logic [XW-1:0]          pos_x, cnt_x;
  logic [AW-1:0]          pos_a;
  logic                   full, ptr_last, match;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign in_val_w = VALUE_WIDTH'(in_value);
  assign pos_x    = XW'(in_position);
  assign cnt_x    = XW'(count_r);
  assign pos_a    = AW'(in_position);
  assign full     = (count_r == CW'(DEPTH));
  assign ptr_last = (CW'(ptr_r) == count_r - CW'(1));
  assign match    = !scan_r || (rd_q == val_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    iter_nxt       = iter_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    scan_nxt       = scan_r;
    res_data_nxt   = res_data_r;
    res_has_nxt    = res_has_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_has_nxt    = out_has_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;
    out_cursor_nxt = out_cursor_r;
    mem_we         = 1'b0;
    mem_wa         = ptr_r;
    mem_wd         = rd_q;
    mem_re         = 1'b0;
    mem_ra         = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_data_nxt   = '0;
          res_has_nxt    = 1'b0;
          res_status_nxt = ST_OK;
          val_nxt        = in_val_w;
          pos_nxt        = pos_a;
          state_nxt      = S_DONE;
          unique case (in_cmd)
            CMD_APPEND: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = AW'(count_r);
                mem_wd    = in_val_w;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else if (full) begin
                res_status_nxt = ST_FULL;
              end else if (pos_x == cnt_x) begin
                mem_we    = 1'b1;
                mem_wa    = AW'(count_r);
                mem_wd    = in_val_w;
                count_nxt = count_r + CW'(1);
              end else begin
                // walk down from the top entry, moving each one up a slot
                mem_re    = 1'b1;
                mem_ra    = AW'(count_r - CW'(1));
                ptr_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_UP;
              end
            end
            CMD_REMOVE_AT: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = pos_a;
                ptr_nxt   = pos_a;
                scan_nxt  = 1'b0;
                state_nxt = S_HEAD;
              end
            end
            CMD_REMOVE_VAL: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                ptr_nxt   = '0;
                scan_nxt  = 1'b1;
                state_nxt = S_HEAD;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_GET: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = pos_a;
                state_nxt = S_RD;
              end
            end
            CMD_FIRST: begin
              if (count_r != '0) begin
                iter_nxt  = '0;
                mem_re    = 1'b1;
                mem_ra    = '0;
                state_nxt = S_RD;
              end
            end
            CMD_NEXT: begin
              if ((CW'(iter_r) + CW'(1)) < count_r) begin
                iter_nxt  = iter_r + AW'(1);
                mem_re    = 1'b1;
                mem_ra    = iter_r + AW'(1);
                state_nxt = S_RD;
              end
            end
            CMD_REPLACE: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_we = 1'b1;
                mem_wa = pos_a;
                mem_wd = in_val_w;
              end
            end
            default: ;
          endcase
        end
      end
      S_UP: begin
        // rd_q holds entry ptr_r; move it to ptr_r + 1
        mem_we = 1'b1;
        mem_wa = ptr_r + AW'(1);
        mem_wd = rd_q;
        if (ptr_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r - AW'(1);
          ptr_nxt = ptr_r - AW'(1);
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r;
        mem_wd    = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_HEAD: begin
        // head of a removal, or one compare step of a search
        if (match) begin
          res_data_nxt = rd_q;
          res_has_nxt  = 1'b1;
        end
        if (ptr_last) begin
          if (match) begin
            count_nxt = count_r - CW'(1);
          end
          state_nxt = S_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
          if (match) begin
            state_nxt = S_DN;
          end
        end
      end
      S_DN: begin
        mem_we = 1'b1;
        mem_wa = ptr_r - AW'(1);
        mem_wd = rd_q;
        if (ptr_last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_RD: begin
        res_data_nxt = rd_q;
        res_has_nxt  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = VAL_W'(res_data_r);
          out_has_nxt    = res_has_r;
          out_status_nxt = res_status_r;
          out_length_nxt = LEN_W'(count_r);
          out_cursor_nxt = CURSOR_W'(iter_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    scan_r       <= scan_nxt;
    res_data_r   <= res_data_nxt;
    res_has_r    <= res_has_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
    out_cursor_r <= out_cursor_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_has_data = out_has_r;
  assign out_status   = out_status_r;
  assign out_length   = out_length_r;
  assign out_cursor   = out_cursor_r;

  // every accepted item takes the engine out of idle in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("engine idle right after accepting an item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond store depth");

  // shifts never read and write the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("RAM read and write to the same entry");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> !out_has_r)
    else $error("error result carries data");

endmodule

### sim/indexed_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_engine_unit: directed, fill-to-capacity and
// random list commands with an in-bench list predictor. Depends on ile_pkg and the RTL.
module indexed_list_engine_unit_tb;
  import ile_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int STALL_LIMIT = 4 * (LIST_DEPTH + 2) + 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [VAL_W-1:0]    data;
    logic                has;
    status_t             status;
    logic [LEN_W-1:0]    length;
    logic [CURSOR_W-1:0] cursor;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic [VAL_W-1:0]    in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VAL_W-1:0]    out_data_out;
  logic                out_has_data;
  logic [1:0]          out_status;
  logic [LEN_W-1:0]    out_length;
  logic [CURSOR_W-1:0] out_cursor;

  // predicted list contents
  logic [VAL_W-1:0]    list_mem [LIST_DEPTH];
  int                  list_len = 0;
  logic [CURSOR_W-1:0] list_cursor = '0;

  list_result_t pending_results[$];
  int error_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  indexed_list_engine_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_has_data (out_has_data),
    .out_status   (out_status),
    .out_length   (out_length),
    .out_cursor   (out_cursor)
  );

  always #10 clk = ~clk;

  function automatic void drop_entry(int at);
    int i;
    for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  function automatic list_result_t predict_result(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                                                  logic [VAL_W-1:0] v);
    list_result_t r;
    int i;
    int hit;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = v;
          list_len++;
        end
      end
      CMD_INSERT: begin
        // range error wins over full
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
          list_mem[p] = v;
          list_len++;
        end
      end
      CMD_REMOVE_AT: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = list_mem[p];
          r.has = 1'b1;
          drop_entry(p);
        end
      end
      CMD_REMOVE_VAL: begin
        hit = -1;
        for (i = 0; i < list_len; i++) if (hit < 0 && list_mem[i] == v) hit = i;
        if (hit >= 0) begin
          r.data = list_mem[hit];
          r.has = 1'b1;
          drop_entry(hit);
        end
      end
      CMD_CLEAR: list_len = 0;
      CMD_GET: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = list_mem[p];
          r.has = 1'b1;
        end
      end
      CMD_FIRST: begin
        if (list_len > 0) begin
          list_cursor = '0;
          r.data = list_mem[0];
          r.has = 1'b1;
        end
      end
      CMD_NEXT: begin
        if (list_len > 0 && list_cursor + 1 < list_len) begin
          list_cursor++;
          r.data = list_mem[list_cursor];
          r.has = 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (p >= list_len) r.status = ST_RANGE;
        else list_mem[p] = v;
      end
      default: ;
    endcase
    r.length = LEN_W'(list_len);
    r.cursor = list_cursor;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // valid is only lowered when the sender idles, never in the step it is raised again
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                           input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= c;
    in_position <= p;
    in_value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(c, p, v));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected: data %0h status %0d length %0d",
                 $time, out_data_out, out_status, out_length);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", want.data, out_data_out);
        check_field("has_data", want.has, out_has_data);
        check_field("status", want.status, out_status);
        check_field("length", want.length, out_length);
        check_field("cursor", want.cursor, out_cursor);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(CMD_FIRST, 8'd0, 32'h0);           // empty list: no data
    send_item(CMD_NEXT, 8'd0, 32'h0);
    send_item(CMD_GET, 8'd0, 32'h0);             // out of range on empty
    send_item(CMD_REMOVE_AT, 8'd255, 32'h0);
    send_item(CMD_REPLACE, 8'd0, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE_VAL, 8'd0, 32'h0);      // no match
    send_item(CMD_INSERT, 8'd1, 32'h1);          // beyond length
    send_item(CMD_INSERT, 8'd0, 32'h0);
    send_item(CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, 8'd0, 32'h1234_5678);
    send_item(CMD_INSERT, 8'd3, 32'h1);          // insert at length appends
    send_item(CMD_INSERT, 8'd1, 32'hA5A5_A5A5);
    send_item(CMD_GET, 8'd4, 32'h0);
    send_item(CMD_GET, 8'd5, 32'h0);
    send_item(CMD_FIRST, 8'd0, 32'h0);
    send_item(CMD_NEXT, 8'd0, 32'h0);
    send_item(CMD_REPLACE, 8'd2, 32'h5A5A_5A5A);
    send_item(CMD_REMOVE_VAL, 8'd0, 32'h1234_5678);
    send_item(CMD_REMOVE_AT, 8'd0, 32'h0);       // cursor stays put
    send_item(CMD_REMOVE_AT, 8'd2, 32'h0);
    send_item(CMD_NEXT, 8'd0, 32'h0);            // cursor at the end
    send_item(CMD_UNUSED_LO, 8'd17, 32'hDEAD_BEEF);
    send_item(CMD_UNUSED_HI, 8'd255, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 8'd0, 32'h0);
    send_item(CMD_GET, 8'd255, 32'h0);
  endtask

  // entries keep bit 31 low so the all-ones search below cannot match
  task automatic test_fill_to_capacity();
    send_item(CMD_CLEAR, 8'd0, 32'h0);
    while (list_len < LIST_DEPTH) send_item(CMD_APPEND, 8'($urandom), {1'b0, 31'($urandom)});
    send_item(CMD_APPEND, 8'd0, 32'h1);
    send_item(CMD_INSERT, 8'd0, 32'h1);
    send_item(CMD_INSERT, 8'd255, 32'h1);
    send_item(CMD_GET, 8'd255, 32'h0);
    send_item(CMD_REPLACE, 8'd255, 32'h7FFF_FFFF);
    send_item(CMD_REMOVE_AT, 8'd0, 32'h0);
    send_item(CMD_INSERT, 8'd0, 32'h0);
    send_item(CMD_REMOVE_VAL, 8'd0, list_mem[LIST_DEPTH - 1]);
    send_item(CMD_APPEND, 8'd0, 32'h0000_0003);
    send_item(CMD_REMOVE_VAL, 8'd0, 32'hFFFF_FFFF);
    send_item(CMD_FIRST, 8'd0, 32'h0);
    repeat (LIST_DEPTH) send_item(CMD_NEXT, 8'($urandom), 32'($urandom));
    send_item(CMD_CLEAR, 8'd0, 32'h0);
  endtask

  task automatic test_random(input int n_items);
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;
    logic [VAL_W-1:0] v;
    int pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 18) c = CMD_APPEND;
      else if (pick < 34) c = CMD_INSERT;
      else if (pick < 46) c = CMD_REMOVE_AT;
      else if (pick < 58) c = CMD_REMOVE_VAL;
      else if (pick < 68) c = CMD_GET;
      else if (pick < 73) c = CMD_FIRST;
      else if (pick < 85) c = CMD_NEXT;
      else if (pick < 93) c = CMD_REPLACE;
      else if (pick < 96) c = CMD_CLEAR;
      else c = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      // keep lists short so shifts stay cheap
      if (list_len > 40 && (c == CMD_APPEND || c == CMD_INSERT)) c = CMD_REMOVE_AT;

      if ($urandom_range(99) < 80)
        p = (list_len > 255) ? 8'($urandom_range(255)) : 8'($urandom_range(list_len));
      else
        p = 8'($urandom_range(255));

      pick = $urandom_range(99);
      if (list_len > 0 && (pick < 20 || (c == CMD_REMOVE_VAL && pick < 75)))
        v = list_mem[$urandom_range(list_len - 1)];
      else if (pick < 35) v = $urandom_range(3);     // small pool makes duplicates
      else if (pick < 42) v = $urandom_range(1) ? '1 : '0;
      else v = $urandom;
      send_item(c, p, v);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 70;
    test_directed();
    test_random(300);
    test_fill_to_capacity();
    wait_for_drain();

    send_idle_pct = 70;
    recv_idle_pct = 26;
    test_random(300);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(280);
    wait_for_drain();

    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### indexed_list_engine_unit.f
sv/ile_pkg.sv
sv/indexed_list_engine_unit.sv
sim/indexed_list_engine_unit_tb.sv
